>>> src/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and codes for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

   // depth_mode codes, anything above DEPTH_32 decodes as 24-bit
   localparam logic [2:0] DEPTH_GREY8 = 3'd0;
   localparam logic [2:0] DEPTH_15    = 3'd1;
   localparam logic [2:0] DEPTH_16    = 3'd2;
   localparam logic [2:0] DEPTH_24    = 3'd3;
   localparam logic [2:0] DEPTH_32    = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_DEPTH_MODE   = 2'd0;
   localparam logic [1:0] CSR_ALPHA_ENABLE = 2'd1;
   localparam logic [1:0] CSR_RLE_ENABLE   = 2'd2;
   localparam logic [1:0] CSR_ROW_WIDTH    = 2'd3;

   // configuration reset values
   localparam logic [2:0]  DEPTH_MODE_RST   = DEPTH_24;
   localparam logic        ALPHA_ENABLE_RST = 1'b0;
   localparam logic        RLE_ENABLE_RST   = 1'b1;
   localparam logic [15:0] ROW_WIDTH_RST    = 16'd640;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_RUN    = 2'd1,
      PH_RAW    = 2'd2
   } phase_type;

   typedef struct packed {
      logic [2:0]  depth_mode;
      logic        alpha_enable;
      logic        rle_enable;
      logic [15:0] row_width;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] pixel_bytes;
      logic [7:0]  run_length;
      logic        row_end;
   } pix_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } color_type;

endpackage

>>> src/trd_packet_ctrl.sv
// ----------------------------------------------------------------------------
// trd_packet_ctrl
// Packet header parsing, pixel byte assembly and row/run length tracking.
// ----------------------------------------------------------------------------
module trd_packet_ctrl import trd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic [7:0] data_byte,
   output pix_type    pix
);

   phase_type   phase_ff, phase_in;
   logic [1:0]  byte_index_ff, byte_index_in;
   logic [31:0] pixel_bytes_ff, pixel_bytes_in;
   logic [7:0]  run_count_ff, run_count_in;
   logic [7:0]  raw_left_ff, raw_left_in;
   logic [15:0] column_ff, column_in;

   logic        header_step;
   logic [1:0]  last_index;
   logic        pixel_done;
   logic [31:0] merged_bytes;
   logic [15:0] width_eff;
   logic [15:0] left;
   logic [7:0]  run_len;
   logic        ends;
   logic [7:0]  len;
   logic [7:0]  raw_dec;

   // shared datapath
   always_comb begin
      header_step = cfg.rle_enable && (phase_ff == PH_HEADER);
      case (cfg.depth_mode)
         DEPTH_GREY8: last_index = 2'd0;
         DEPTH_15:    last_index = 2'd1;
         DEPTH_16:    last_index = 2'd1;
         DEPTH_32:    last_index = 2'd3;
         default:     last_index = 2'd2;
      endcase
      pixel_done = (byte_index_ff >= last_index);

      merged_bytes = pixel_bytes_ff;
      case (byte_index_ff)
         2'd0:    merged_bytes[7:0]   = data_byte;
         2'd1:    merged_bytes[15:8]  = data_byte;
         2'd2:    merged_bytes[23:16] = data_byte;
         default: merged_bytes[31:24] = data_byte;
      endcase

      width_eff = (cfg.row_width == 16'd0) ? 16'd1 : cfg.row_width;
      left      = (column_ff < width_eff) ? (width_eff - column_ff) : 16'd1;
      if (cfg.rle_enable && (phase_ff == PH_RUN)) begin
         run_len = (run_count_ff == 8'd0) ? 8'd1 : run_count_ff;
      end else begin
         run_len = 8'd1;
      end
      // clipped length never exceeds run_len, so left fits in 8 bits there
      ends    = ({8'd0, run_len} >= left);
      len     = ends ? left[7:0] : run_len;
      raw_dec = raw_left_ff - 8'd1;
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      pixel_bytes_in = pixel_bytes_ff;
      run_count_in   = run_count_ff;
      raw_left_in    = raw_left_ff;
      column_in      = column_ff;
      if (step) begin
         if (header_step) begin
            if (data_byte[7]) begin
               run_count_in = data_byte - 8'd127;
               phase_in     = PH_RUN;
            end else begin
               raw_left_in = data_byte + 8'd1;
               phase_in    = PH_RAW;
            end
            byte_index_in = 2'd0;
         end else if (!pixel_done) begin
            pixel_bytes_in = merged_bytes;
            byte_index_in  = byte_index_ff + 2'd1;
         end else begin
            byte_index_in = 2'd0;
            if (ends) begin
               column_in    = 16'd0;
               run_count_in = 8'd0;
               raw_left_in  = 8'd0;
               phase_in     = PH_HEADER;
            end else begin
               column_in = column_ff + {8'd0, len};
               if (cfg.rle_enable) begin
                  if (phase_ff == PH_RUN) begin
                     run_count_in = 8'd0;
                     phase_in     = PH_HEADER;
                  end else begin
                     raw_left_in = raw_dec;
                     if (raw_dec == 8'd0) begin
                        phase_in = PH_HEADER;
                     end
                  end
               end
            end
         end
      end
   end

   // outputs
   always_comb begin
      pix.valid       = step && !header_step && pixel_done;
      pix.pixel_bytes = merged_bytes;
      pix.run_length  = len;
      pix.row_end     = ends;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         byte_index_ff <= 2'd0;
         run_count_ff  <= 8'd0;
         raw_left_ff   <= 8'd0;
         column_ff     <= 16'd0;
      end else begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         run_count_ff  <= run_count_in;
         raw_left_ff   <= raw_left_in;
         column_ff     <= column_in;
      end
   end

   // bytes above the current index are always rewritten before a pixel uses them
   always_ff @(posedge clock) begin
      pixel_bytes_ff <= pixel_bytes_in;
   end

endmodule

>>> src/trd_color_expand.sv
// ----------------------------------------------------------------------------
// trd_color_expand
// Expands an assembled pixel of any supported depth to 8-bit RGBA.
// ----------------------------------------------------------------------------
module trd_color_expand import trd_pkg::*; (
   input  cfg_type     cfg,
   input  logic [31:0] pixel_bytes,
   output color_type   color
);

   // v*255/31 and v*255/63 as multiply by reciprocal, exact over the input range
   localparam logic [23:0] SCALE5_MUL = 24'd8625630;
   localparam logic [23:0] SCALE6_MUL = 24'd4244475;

   function automatic logic [7:0] scale5(input logic [4:0] v);
      logic [28:0] p;
      p = 29'(v) * 29'(SCALE5_MUL);
      return p[27:20];
   endfunction

   function automatic logic [7:0] scale6(input logic [5:0] v);
      logic [28:0] p;
      p = 29'(v) * 29'(SCALE6_MUL);
      return p[27:20];
   endfunction

   logic [15:0] word;

   always_comb begin
      word        = pixel_bytes[15:0];
      color.alpha = 8'hff;
      case (cfg.depth_mode)
         DEPTH_GREY8: begin
            color.red   = pixel_bytes[7:0];
            color.green = pixel_bytes[7:0];
            color.blue  = pixel_bytes[7:0];
         end
         DEPTH_15: begin
            color.red   = scale5(word[14:10]);
            color.green = scale5(word[9:5]);
            color.blue  = scale5(word[4:0]);
            if (cfg.alpha_enable) begin
               color.alpha = word[15] ? 8'hff : 8'h00;
            end
         end
         DEPTH_16: begin
            color.red   = scale5(word[15:11]);
            color.green = scale6(word[10:5]);
            color.blue  = scale5(word[4:0]);
         end
         DEPTH_32: begin
            color.red   = pixel_bytes[23:16];
            color.green = pixel_bytes[15:8];
            color.blue  = pixel_bytes[7:0];
            color.alpha = pixel_bytes[31:24];
         end
         default: begin
            color.red   = pixel_bytes[23:16];
            color.green = pixel_bytes[15:8];
            color.blue  = pixel_bytes[7:0];
         end
      endcase
   end

endmodule

>>> src/tga_rle_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// TGA scanline decoder: run-length packets or raw bytes in, RGBA runs out.
// ----------------------------------------------------------------------------
//  channel  | ports                                      | beat
//  ---------+--------------------------------------------+---------------------
//  request  | req_valid/req_ready, req_data_byte         | one stream byte
//  response | rsp_valid/rsp_ready, rsp_red..rsp_row_end  | one decoded run
//  csr      | csr_write_enable, csr_index, csr_write_data| one register write
//
//  one byte per cycle sustained while the response is not stalled; a byte is held
//  in the input register, then decoded into the response register.
//  header bytes and partial pixel bytes produce no response beat.
//  synchronous reset clears packet state and loads register defaults.
//  a stalled response holds the input register; req_ready drops only then.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_unit import trd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_run_length,
   output logic        rsp_row_end,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   cfg_type     cfg_ff, cfg_in;
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   color_type   color_ff;
   logic [7:0]  run_length_ff;
   logic        row_end_ff;

   logic        out_free;
   logic        step;
   pix_type     pix;
   color_type   color;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEPTH_MODE:   cfg_in.depth_mode   = csr_write_data[2:0];
            CSR_ALPHA_ENABLE: cfg_in.alpha_enable = csr_write_data[0];
            CSR_RLE_ENABLE:   cfg_in.rle_enable   = csr_write_data[0];
            CSR_ROW_WIDTH:    cfg_in.row_width    = csr_write_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (step) begin
         rsp_valid_in = pix.valid;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   trd_packet_ctrl u_packet_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step      (step),
      .data_byte (in_byte_ff),
      .pix       (pix)
   );

   trd_color_expand u_color_expand (
      .cfg         (cfg_ff),
      .pixel_bytes (pix.pixel_bytes),
      .color       (color)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth_mode   <= DEPTH_MODE_RST;
         cfg_ff.alpha_enable <= ALPHA_ENABLE_RST;
         cfg_ff.rle_enable   <= RLE_ENABLE_RST;
         cfg_ff.row_width    <= ROW_WIDTH_RST;
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
      if (pix.valid) begin
         color_ff      <= color;
         run_length_ff <= pix.run_length;
         row_end_ff    <= pix.row_end;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red        = color_ff.red;
   assign rsp_green      = color_ff.green;
   assign rsp_blue       = color_ff.blue;
   assign rsp_alpha      = color_ff.alpha;
   assign rsp_run_length = run_length_ff;
   assign rsp_row_end    = row_end_ff;

   // a run always covers between one and a full packet of pixels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_length != 8'd0) && (rsp_run_length <= 8'd128))
      else $error("response run length out of range");

   // a byte waiting behind a stalled response stays in the input register
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a byte during a stall");

   // a pending response is only replaced after it has been taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_run_length)
         && $stable(rsp_red) && $stable(rsp_row_end))
      else $error("pending response overwritten");

endmodule

>>> dv/tga_pixel_run_checker.sv
// ----------------------------------------------------------------------------
// tga_pixel_run_checker
// Watches the byte, run and register ports of the TGA pixel decoder, keeps
// its own decode state, predicts every RGBA run and compares each response
// beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tga_pixel_run_checker import trd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_blue,
   input  logic [7:0]  rsp_alpha,
   input  logic [7:0]  rsp_run_length,
   input  logic        rsp_row_end,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   output int unsigned runs_pending,
   output int unsigned error_count
);

   typedef struct packed {
      color_type  color;
      logic [7:0] run_length;
      logic       row_end;
   } run_beat_type;

   cfg_type      cfg;
   phase_type    phase;
   logic [1:0]   byte_idx;
   logic [31:0]  pix_bytes;
   logic [7:0]   run_cnt;
   logic [7:0]   raw_cnt;
   logic [15:0]  column;
   run_beat_type decoded_runs[$];
   int unsigned  errors = 0;

   function automatic logic [7:0] widen_field(input int code, input int max_code);
      return 8'(((code & max_code) * 255) / max_code);
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic decode_stream_byte(input logic [7:0] d);
      int           width_eff;
      int           left;
      int           bpp;
      int           len;
      int           word;
      run_beat_type beat;
      width_eff = (cfg.row_width == 16'd0) ? 1 : int'(cfg.row_width);
      if (cfg.rle_enable && phase == PH_HEADER) begin
         if (d >= 8'd128) begin
            run_cnt = d - 8'd127;
            phase   = PH_RUN;
         end else begin
            raw_cnt = d + 8'd1;
            phase   = PH_RAW;
         end
         byte_idx  = 2'd0;
         pix_bytes = 32'd0;
      end else begin
         pix_bytes[byte_idx*8 +: 8] = d;
         case (cfg.depth_mode)
            DEPTH_GREY8:      bpp = 1;
            DEPTH_15, DEPTH_16: bpp = 2;
            DEPTH_32:         bpp = 4;
            default:          bpp = 3;
         endcase
         if (int'(byte_idx) + 1 < bpp) begin
            byte_idx = byte_idx + 2'd1;
         end else begin
            word = int'(pix_bytes[15:0]);
            beat.color.alpha = 8'd255;
            case (cfg.depth_mode)
               DEPTH_GREY8: begin
                  beat.color.red   = pix_bytes[7:0];
                  beat.color.green = pix_bytes[7:0];
                  beat.color.blue  = pix_bytes[7:0];
               end
               DEPTH_15: begin
                  beat.color.red   = widen_field(word >> 10, 31);
                  beat.color.green = widen_field(word >> 5, 31);
                  beat.color.blue  = widen_field(word, 31);
                  if (cfg.alpha_enable)
                     beat.color.alpha = pix_bytes[15] ? 8'd255 : 8'd0;
               end
               DEPTH_16: begin
                  beat.color.red   = widen_field(word >> 11, 31);
                  beat.color.green = widen_field(word >> 5, 63);
                  beat.color.blue  = widen_field(word, 31);
               end
               DEPTH_32: begin
                  beat.color.red   = pix_bytes[23:16];
                  beat.color.green = pix_bytes[15:8];
                  beat.color.blue  = pix_bytes[7:0];
                  beat.color.alpha = pix_bytes[31:24];
               end
               default: begin
                  beat.color.red   = pix_bytes[23:16];
                  beat.color.green = pix_bytes[15:8];
                  beat.color.blue  = pix_bytes[7:0];
               end
            endcase
            // a column past the row (width lowered mid-row) leaves room for one
            left = (int'(column) < width_eff) ? width_eff - int'(column) : 1;
            if (cfg.rle_enable && phase == PH_RUN)
               len = (run_cnt != 8'd0) ? int'(run_cnt) : 1;
            else
               len = 1;
            if (len > left)
               len = left;
            beat.run_length = 8'(len);
            beat.row_end    = (len >= left);
            if (beat.row_end) begin
               column  = 16'd0;
               run_cnt = 8'd0;
               raw_cnt = 8'd0;
               phase   = PH_HEADER;
            end else begin
               column = column + 16'(len);
               if (cfg.rle_enable) begin
                  if (phase == PH_RUN) begin
                     run_cnt = 8'd0;
                     phase   = PH_HEADER;
                  end else begin
                     raw_cnt = raw_cnt - 8'd1;
                     if (raw_cnt == 8'd0)
                        phase = PH_HEADER;
                  end
               end
            end
            byte_idx  = 2'd0;
            pix_bytes = 32'd0;
            decoded_runs.push_back(beat);
         end
      end
   endtask

   always @(posedge clock) begin
      run_beat_type want;
      if (reset) begin
         cfg.depth_mode   = DEPTH_MODE_RST;
         cfg.alpha_enable = ALPHA_ENABLE_RST;
         cfg.rle_enable   = RLE_ENABLE_RST;
         cfg.row_width    = ROW_WIDTH_RST;
         phase     = PH_HEADER;
         byte_idx  = 2'd0;
         pix_bytes = 32'd0;
         run_cnt   = 8'd0;
         raw_cnt   = 8'd0;
         column    = 16'd0;
         decoded_runs.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (decoded_runs.size() == 0) begin
               $display("%0t unexpected response beat: expected none, actual rgba %0d %0d %0d %0d",
                        $time, rsp_red, rsp_green, rsp_blue, rsp_alpha);
               errors++;
            end else begin
               want = decoded_runs.pop_front();
               check_field("red", want.color.red, rsp_red);
               check_field("green", want.color.green, rsp_green);
               check_field("blue", want.color.blue, rsp_blue);
               check_field("alpha", want.color.alpha, rsp_alpha);
               check_field("run_length", want.run_length, rsp_run_length);
               check_field("row_end", want.row_end, rsp_row_end);
            end
         end
         if (req_valid && req_ready)
            decode_stream_byte(req_data_byte);
         if (csr_write_enable) begin
            case (csr_index)
               CSR_DEPTH_MODE:   cfg.depth_mode   = csr_write_data[2:0];
               CSR_ALPHA_ENABLE: cfg.alpha_enable = csr_write_data[0];
               CSR_RLE_ENABLE:   cfg.rle_enable   = csr_write_data[0];
               CSR_ROW_WIDTH:    cfg.row_width    = csr_write_data;
               default: ;
            endcase
         end
      end
      runs_pending <= decoded_runs.size();
      error_count  <= errors;
   end

endmodule

>>> dv/tb_tga_rle_pixel_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_unit
// Drives TGA byte streams into the pixel decoder: a directed pass over the
// packet corner cases, then random packet streams under changing register
// settings and back-pressure, with a side checker predicting every run.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder_unit;
   import trd_pkg::*;

   localparam int SEGMENTS      = 12;
   localparam int SEGMENT_BYTES = 88;
   localparam int SETTLE_CYCLES = 6;
   localparam int LONG_HOLD     = 300;
   localparam int DRAIN_LIMIT   = 50000;
   localparam int RUN_LIMIT     = 1600000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_run_length;
   logic        rsp_row_end;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_write_data = 16'd0;

   int unsigned runs_pending;
   int unsigned error_count;

   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_armed = 1'b0;
   int unsigned hold_cycles = 0;
   int unsigned bytes_sent = 0;
   logic [2:0]  cur_depth = DEPTH_MODE_RST;
   logic        cur_rle = RLE_ENABLE_RST;

   tga_rle_pixel_decoder_unit u_dut (.*);

   tga_pixel_run_checker u_run_checker (.*);

   always #2 clock = ~clock;

   // receiver: one long hold-off once armed, random stalls otherwise
   always @(negedge clock) begin
      if (hold_armed && hold_cycles < LONG_HOLD) begin
         rsp_ready   <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("simulation failed");
      $finish;
   end

   function automatic int pixel_size(input logic [2:0] depth);
      case (depth)
         DEPTH_GREY8:        return 1;
         DEPTH_15, DEPTH_16: return 2;
         DEPTH_32:           return 4;
         default:            return 3;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      @(negedge clock);
      bytes_sent++;
   endtask

   // stop offering, wait for every run, then let the input and response registers drain
   task automatic settle_block();
      req_valid <= 1'b0;
      while (runs_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [15:0] value);
      logic [15:0] data;
      data = value;
      // junk above the narrow registers must be ignored
      if (idx != CSR_ROW_WIDTH && $urandom_range(0, 3) == 0)
         data = data | (16'($urandom) << 3);
      if (idx == CSR_DEPTH_MODE)
         cur_depth = value[2:0];
      if (idx == CSR_RLE_ENABLE)
         cur_rle = value[0];
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_config(input logic [2:0] depth, input logic alpha,
                               input logic rle, input logic [15:0] width);
      settle_block();
      set_reg(CSR_DEPTH_MODE, 16'(depth));
      set_reg(CSR_ALPHA_ENABLE, 16'(alpha));
      set_reg(CSR_RLE_ENABLE, 16'(rle));
      set_reg(CSR_ROW_WIDTH, width);
   endtask

   // mostly well-formed packets with random pixels, some noise and cut packets
   task automatic send_packets(input int budget);
      int unsigned stop_at;
      int          kind;
      int          count;
      int          n;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         if (!cur_rle || kind < 12) begin
            send_byte(8'($urandom));
         end else begin
            if (kind < 55) begin
               count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 15);
               send_byte(8'(128 + count));
               n = pixel_size(cur_depth);
            end else begin
               count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 5);
               send_byte(8'(count));
               n = (count + 1) * pixel_size(cur_depth);
            end
            if ($urandom_range(0, 19) == 0)
               n = $urandom_range(0, n - 1);
            for (int i = 0; i < n && bytes_sent < stop_at; i++)
               send_byte(8'($urandom));
         end
      end
   endtask

   task automatic random_config();
      logic [2:0]  depth;
      logic [15:0] width;
      int          pick;
      depth = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                          : 3'($urandom_range(0, 4));
      pick = $urandom_range(0, 9);
      case (pick)
         0:       width = 16'd0;
         1:       width = 16'd1;
         2:       width = 16'hffff;
         3, 4, 5: width = 16'($urandom_range(2, 8));
         6, 7, 8: width = 16'($urandom_range(9, 40));
         default: width = 16'($urandom_range(41, 700));
      endcase
      apply_config(depth, 1'($urandom_range(0, 1)), ($urandom_range(0, 4) != 0), width);
   endtask

   initial begin
      int mode;
      int guard;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // run of 128 clipped at a short row
      apply_config(DEPTH_GREY8, 1'b0, 1'b1, 16'd3);
      send_byte(8'hff);
      send_byte(8'hab);
      // literal packet longer than the row
      send_byte(8'h05);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h7f);
      // raw stream, 15-bit with alpha then 16-bit
      settle_block();
      set_reg(CSR_RLE_ENABLE, 16'd0);
      set_reg(CSR_DEPTH_MODE, 16'(DEPTH_15));
      set_reg(CSR_ALPHA_ENABLE, 16'd1);
      send_byte(8'hff);
      send_byte(8'h7f);
      send_byte(8'h00);
      send_byte(8'h80);
      settle_block();
      set_reg(CSR_DEPTH_MODE, 16'(DEPTH_16));
      send_byte(8'he0);
      send_byte(8'h07);
      // undefined depth code with zero row width
      apply_config(3'd5, 1'b0, 1'b1, 16'd0);
      send_byte(8'h00);
      send_byte(8'haa);
      send_byte(8'hbb);
      send_byte(8'hcc);
      // row width lowered below the current column
      apply_config(DEPTH_GREY8, 1'b0, 1'b1, 16'd10);
      send_byte(8'h84);
      send_byte(8'h55);
      settle_block();
      set_reg(CSR_ROW_WIDTH, 16'd3);
      send_byte(8'h80);
      send_byte(8'h66);
      // depth changed with a pixel half collected
      apply_config(DEPTH_32, 1'b0, 1'b1, 16'd640);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h02);
      settle_block();
      set_reg(CSR_DEPTH_MODE, 16'(DEPTH_16));
      send_byte(8'h03);
      // run-length coding toggled inside a literal packet
      settle_block();
      set_reg(CSR_DEPTH_MODE, 16'(DEPTH_GREY8));
      send_byte(8'h01);
      send_byte(8'h10);
      settle_block();
      set_reg(CSR_RLE_ENABLE, 16'd0);
      send_byte(8'h20);
      settle_block();
      set_reg(CSR_RLE_ENABLE, 16'd1);
      send_byte(8'h30);

      for (int k = 0; k < SEGMENTS; k++) begin
         case (k)
            0:       apply_config(DEPTH_32, 1'b0, 1'b1, 16'hffff);
            1:       apply_config(DEPTH_GREY8, 1'b0, 1'b1, 16'd1);
            2:       apply_config(3'd7, 1'b1, 1'b0, 16'd2);
            3:       apply_config(DEPTH_15, 1'b1, 1'b1, 16'd17);
            default: random_config();
         endcase
         mode = k % 4;
         send_idle_pct = (mode == 1) ? 60 : (mode == 3) ? 27 : 0;
         stall_pct    <= (mode == 2) ? 60 : (mode == 3) ? 27 : 0;
         // long receiver hold-off while the sender keeps offering
         if (k == 4)
            hold_armed <= 1'b1;
         send_packets(SEGMENT_BYTES / 2);
         if (k % 3 == 1)
            settle_block();
         send_packets(SEGMENT_BYTES - SEGMENT_BYTES / 2);
      end

      req_valid <= 1'b0;
      stall_pct <= 0;
      guard = 0;
      while (runs_pending != 0 && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (runs_pending != 0)
         $display("%0t %0d expected runs never arrived", $time, runs_pending);
      if (error_count == 0 && runs_pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
src/trd_pkg.sv
src/trd_packet_ctrl.sv
src/trd_color_expand.sv
src/tga_rle_pixel_decoder_unit.sv
dv/tga_pixel_run_checker.sv
dv/tb_tga_rle_pixel_decoder_unit.sv
